// File: rtl/dryer_heater_sequencer_core_macros.svh
// ----------------------------------------------------------------------------
// Dryer heater sequencer assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DRYER_HEATER_SEQUENCER_CORE_MACROS_SVH
`define DRYER_HEATER_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and ignored while rst_n is low.
`define DHS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dryer heater sequencer: assertion failed");

// Next-cycle implication, sampled on clk and ignored while rst_n is low.
`define DHS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dryer heater sequencer: assertion failed");

`endif

// File: rtl/dhs_pkg.sv
// ----------------------------------------------------------------------------
// Dryer heater sequencer package
// Types, codes, reset values and a helper function shared by the RTL files.
// ----------------------------------------------------------------------------
package dhs_pkg;

  localparam int unsigned TEMP_W  = 7;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned DWELL_W = 16;
  localparam int unsigned FAULT_W = 6;
  localparam int unsigned COOL_W  = 8;
  localparam int unsigned STAGE_W = 3;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_TEMP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REHEAT_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_TICKS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_TICKS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COOL_TEMP     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COOL_SAMPLES  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT_SAMPLES = 3'd7;

  // Configuration reset values.
  localparam logic [TEMP_W-1:0]  RST_STABLE_TEMP    = 7'd60;
  localparam logic [DWELL_W-1:0] RST_SETTLE_TICKS   = 16'd1000;
  localparam logic [DWELL_W-1:0] RST_REHEAT_TICKS   = 16'd2000;
  localparam logic [DWELL_W-1:0] RST_FULL_TICKS     = 16'd5000;
  localparam logic [DWELL_W-1:0] RST_COOLDOWN_TICKS = 16'd30000;
  localparam logic [TEMP_W-1:0]  RST_COOL_TEMP      = 7'd35;
  localparam logic [COOL_W-1:0]  RST_COOL_SAMPLES   = 8'd10;
  localparam logic [FAULT_W-1:0] RST_FAULT_SAMPLES  = 6'd50;

  localparam logic [TEMP_W-1:0] RST_LAST_TEMP = 7'd90;
  localparam logic [TEMP_W-1:0] TEMP_OOR_HIGH = 7'd99;

  // Run phases.
  localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_SETTLE = 2'd1;
  localparam logic [PHASE_W-1:0] PH_HEAT   = 2'd2;
  localparam logic [PHASE_W-1:0] PH_COOL   = 2'd3;

  // Heater sequencer stages.
  localparam logic [STAGE_W-1:0] STG_START     = 3'd0;
  localparam logic [STAGE_W-1:0] STG_HIGH      = 3'd1;
  localparam logic [STAGE_W-1:0] STG_REHEAT    = 3'd2;
  localparam logic [STAGE_W-1:0] STG_BOTH      = 3'd3;
  localparam logic [STAGE_W-1:0] STG_HOLD      = 3'd4;
  localparam logic [STAGE_W-1:0] STG_LOW       = 3'd5;
  localparam logic [STAGE_W-1:0] STG_LAST      = 3'd5;

  // Heater drive codes, bit 0 low heater, bit 1 high heater.
  localparam logic [1:0] DRV_OFF  = 2'd0;
  localparam logic [1:0] DRV_LOW  = 2'd1;
  localparam logic [1:0] DRV_HIGH = 2'd2;
  localparam logic [1:0] DRV_BOTH = 2'd3;

  typedef struct packed {
    logic [TEMP_W-1:0]  stable_temperature;
    logic [DWELL_W-1:0] settle_ticks;
    logic [DWELL_W-1:0] reheat_delay_ticks;
    logic [DWELL_W-1:0] full_dwell_ticks;
    logic [DWELL_W-1:0] cooldown_timeout_ticks;
    logic [TEMP_W-1:0]  cool_temperature;
    logic [COOL_W-1:0]  cool_samples;
    logic [FAULT_W-1:0] fault_samples;
  } cfg_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temperature;
    logic              temperature_valid;
    logic              run_request;
    logic              run_status_ok;
    logic [1:0]        fixed_power;
    logic              display_setup;
    logic [TICK_W-1:0] tick_now;
  } item_t;

  typedef struct packed {
    logic               heater_low_on;
    logic               heater_high_on;
    logic               converter_on;
    logic [PHASE_W-1:0] run_phase;
    logic [STAGE_W-1:0] heat_stage;
    logic               temperature_fault;
    logic [TEMP_W-1:0]  current_temperature;
  } result_t;

  // True once at least limit ticks have passed since stamp, modulo 2^32.
  function automatic logic elapsed(input logic [TICK_W-1:0] now,
                                   input logic [TICK_W-1:0] stamp,
                                   input logic [DWELL_W-1:0] limit);
    logic [TICK_W-1:0] diff;
    diff = now - stamp;
    return diff >= {{(TICK_W-DWELL_W){1'b0}}, limit};
  endfunction

endpackage

// File: rtl/dhs_cfg_regs.sv
// ----------------------------------------------------------------------------
// Dryer heater sequencer configuration registers
// Holds the eight tuning registers written through the configuration port.
// ----------------------------------------------------------------------------
module dhs_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [dhs_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [dhs_pkg::CFG_DATA_W-1:0]  wr_data,
  output dhs_pkg::cfg_t                   cfg
);

  dhs_pkg::cfg_t cfg_r;
  dhs_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        dhs_pkg::CFG_STABLE_TEMP: begin
          cfg_nxt.stable_temperature = wr_data[dhs_pkg::TEMP_W-1:0];
        end
        dhs_pkg::CFG_SETTLE_TICKS: begin
          cfg_nxt.settle_ticks = wr_data[dhs_pkg::DWELL_W-1:0];
        end
        dhs_pkg::CFG_REHEAT_TICKS: begin
          cfg_nxt.reheat_delay_ticks = wr_data[dhs_pkg::DWELL_W-1:0];
        end
        dhs_pkg::CFG_FULL_TICKS: begin
          cfg_nxt.full_dwell_ticks = wr_data[dhs_pkg::DWELL_W-1:0];
        end
        dhs_pkg::CFG_COOLDOWN_TICKS: begin
          cfg_nxt.cooldown_timeout_ticks = wr_data[dhs_pkg::DWELL_W-1:0];
        end
        dhs_pkg::CFG_COOL_TEMP: begin
          cfg_nxt.cool_temperature = wr_data[dhs_pkg::TEMP_W-1:0];
        end
        dhs_pkg::CFG_COOL_SAMPLES: begin
          cfg_nxt.cool_samples = wr_data[dhs_pkg::COOL_W-1:0];
        end
        dhs_pkg::CFG_FAULT_SAMPLES: begin
          cfg_nxt.fault_samples = wr_data[dhs_pkg::FAULT_W-1:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stable_temperature     <= dhs_pkg::RST_STABLE_TEMP;
      cfg_r.settle_ticks           <= dhs_pkg::RST_SETTLE_TICKS;
      cfg_r.reheat_delay_ticks     <= dhs_pkg::RST_REHEAT_TICKS;
      cfg_r.full_dwell_ticks       <= dhs_pkg::RST_FULL_TICKS;
      cfg_r.cooldown_timeout_ticks <= dhs_pkg::RST_COOLDOWN_TICKS;
      cfg_r.cool_temperature       <= dhs_pkg::RST_COOL_TEMP;
      cfg_r.cool_samples           <= dhs_pkg::RST_COOL_SAMPLES;
      cfg_r.fault_samples          <= dhs_pkg::RST_FAULT_SAMPLES;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/dhs_step.sv
// ----------------------------------------------------------------------------
// Dryer heater sequencer control step
// Holds the run state and computes one control period from a registered beat.
// ----------------------------------------------------------------------------
module dhs_step (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  dhs_pkg::cfg_t    cfg,
  input  dhs_pkg::item_t   item,
  output dhs_pkg::result_t result
);

  logic [dhs_pkg::TEMP_W-1:0]  lt_r, lt_nxt;
  logic [dhs_pkg::FAULT_W-1:0] fc_r, fc_nxt;
  logic [dhs_pkg::PHASE_W-1:0] ph_r, ph_nxt;
  logic [dhs_pkg::TICK_W-1:0]  ps_r, ps_nxt;
  logic [dhs_pkg::COOL_W-1:0]  cc_r, cc_nxt;
  logic [dhs_pkg::STAGE_W-1:0] st_r, st_nxt;
  logic [dhs_pkg::TICK_W-1:0]  ss_r, ss_nxt;
  logic [1:0]                  hd_r, hd_nxt;
  logic                        cv_r, cv_nxt;

  always_comb begin
    lt_nxt = lt_r;
    fc_nxt = fc_r;
    ph_nxt = ph_r;
    ps_nxt = ps_r;
    cc_nxt = cc_r;
    st_nxt = st_r;
    ss_nxt = ss_r;
    hd_nxt = hd_r;
    cv_nxt = cv_r;

    if (item.temperature_valid) begin
      lt_nxt = item.temperature;
      if (item.temperature == '0 || item.temperature >= dhs_pkg::TEMP_OOR_HIGH) begin
        if (fc_r != '1) begin
          fc_nxt = fc_r + 1'b1;
        end
      end else begin
        fc_nxt = '0;
      end
    end

    if (item.run_status_ok) begin
      case (ph_r)
        dhs_pkg::PH_IDLE: begin
          if (item.run_request) begin
            ph_nxt = dhs_pkg::PH_SETTLE;
            ps_nxt = item.tick_now;
            cv_nxt = 1'b1;
          end
        end
        dhs_pkg::PH_SETTLE: begin
          if (!item.run_request) begin
            ph_nxt = dhs_pkg::PH_IDLE;
            cv_nxt = 1'b0;
          end
          if (dhs_pkg::elapsed(item.tick_now, ps_r, cfg.settle_ticks)) begin
            ph_nxt = dhs_pkg::PH_HEAT;
          end
        end
        dhs_pkg::PH_HEAT: begin
          if (!item.run_request) begin
            ps_nxt = item.tick_now;
            ph_nxt = dhs_pkg::PH_COOL;
            cc_nxt = '0;
          end
        end
        default: begin
          if (lt_nxt < cfg.cool_temperature) begin
            if (cc_r != '1) begin
              cc_nxt = cc_r + 1'b1;
            end
          end else begin
            cc_nxt = '0;
          end
          if (cc_nxt >= cfg.cool_samples ||
              dhs_pkg::elapsed(item.tick_now, ps_r, cfg.cooldown_timeout_ticks)) begin
            ph_nxt = dhs_pkg::PH_IDLE;
            cv_nxt = 1'b0;
          end
        end
      endcase

      if (ph_nxt == dhs_pkg::PH_HEAT) begin
        if (lt_nxt < cfg.stable_temperature) begin
          case (st_r)
            dhs_pkg::STG_START: begin
              st_nxt = dhs_pkg::STG_BOTH;
            end
            dhs_pkg::STG_HIGH, dhs_pkg::STG_HOLD, dhs_pkg::STG_LOW: begin
              ss_nxt = item.tick_now;
              st_nxt = dhs_pkg::STG_REHEAT;
            end
            dhs_pkg::STG_REHEAT: begin
              if (dhs_pkg::elapsed(item.tick_now, ss_r, cfg.reheat_delay_ticks)) begin
                st_nxt = dhs_pkg::STG_BOTH;
              end
            end
            default: begin
              st_nxt = st_r;
            end
          endcase
        end else begin
          case (st_r)
            dhs_pkg::STG_REHEAT, dhs_pkg::STG_BOTH, dhs_pkg::STG_START: begin
              st_nxt = dhs_pkg::STG_HOLD;
              ss_nxt = item.tick_now;
            end
            dhs_pkg::STG_HOLD: begin
              if (dhs_pkg::elapsed(item.tick_now, ss_r, cfg.reheat_delay_ticks)) begin
                ss_nxt = item.tick_now;
                st_nxt = dhs_pkg::STG_HIGH;
              end
            end
            dhs_pkg::STG_HIGH: begin
              if (dhs_pkg::elapsed(item.tick_now, ss_r, cfg.full_dwell_ticks)) begin
                st_nxt = dhs_pkg::STG_LOW;
              end
            end
            default: begin
              st_nxt = st_r;
            end
          endcase
        end
        case (st_nxt)
          dhs_pkg::STG_BOTH: hd_nxt = dhs_pkg::DRV_BOTH;
          dhs_pkg::STG_HIGH: hd_nxt = dhs_pkg::DRV_HIGH;
          dhs_pkg::STG_LOW:  hd_nxt = dhs_pkg::DRV_LOW;
          default:           hd_nxt = hd_r;
        endcase
      end else begin
        st_nxt = dhs_pkg::STG_START;
        hd_nxt = dhs_pkg::DRV_OFF;
      end
    end else begin
      st_nxt = dhs_pkg::STG_START;
      hd_nxt = dhs_pkg::DRV_OFF;
      cv_nxt = 1'b0;
    end

    if (item.fixed_power != dhs_pkg::DRV_OFF && item.run_request && !item.display_setup) begin
      hd_nxt = item.fixed_power;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= dhs_pkg::RST_LAST_TEMP;
      fc_r <= '0;
      ph_r <= dhs_pkg::PH_IDLE;
      ps_r <= '0;
      cc_r <= '0;
      st_r <= dhs_pkg::STG_START;
      ss_r <= '0;
      hd_r <= dhs_pkg::DRV_OFF;
      cv_r <= 1'b0;
    end else if (fire) begin
      lt_r <= lt_nxt;
      fc_r <= fc_nxt;
      ph_r <= ph_nxt;
      ps_r <= ps_nxt;
      cc_r <= cc_nxt;
      st_r <= st_nxt;
      ss_r <= ss_nxt;
      hd_r <= hd_nxt;
      cv_r <= cv_nxt;
    end
  end

  always_comb begin
    result.heater_low_on       = hd_nxt[0];
    result.heater_high_on      = hd_nxt[1];
    result.converter_on        = cv_nxt;
    result.run_phase           = ph_nxt;
    result.heat_stage          = st_nxt;
    result.temperature_fault   = (fc_nxt >= cfg.fault_samples);
    result.current_temperature = lt_nxt;
  end

endmodule

// File: rtl/dryer_heater_sequencer_core.sv
// ----------------------------------------------------------------------------
// Dryer heater sequencer core
// Run phase machine and hysteretic two-heater sequencer, one control period
// per beat.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Payload
//  in_      input      in_valid/in_stall  temperature, flags, power, tick
//  out_     output     out_valid/out_stall heater, converter, phase, stage
//  cfg_     input      cfg_valid/cfg_ready register index and write data
//
// One beat is accepted per cycle while in_stall is low; it is held in the
// input register, and its result is loaded into the result register when
// the step fires and is offered from there on out_valid. The run state is
// updated as each beat leaves the input register. Reset restores the run
// state and the configuration to their defaults and clears both valid flags.
// A stalled result holds its beat and back-pressure reaches in_stall at once.
// ----------------------------------------------------------------------------
module dryer_heater_sequencer_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [dhs_pkg::TEMP_W-1:0]     in_temperature,
  input  logic                           in_temperature_valid,
  input  logic                           in_run_request,
  input  logic                           in_run_status_ok,
  input  logic [1:0]                     in_fixed_power,
  input  logic                           in_display_setup,
  input  logic [dhs_pkg::TICK_W-1:0]     in_tick_now,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_heater_low_on,
  output logic                           out_heater_high_on,
  output logic                           out_converter_on,
  output logic [dhs_pkg::PHASE_W-1:0]    out_run_phase,
  output logic [dhs_pkg::STAGE_W-1:0]    out_heat_stage,
  output logic                           out_temperature_fault,
  output logic [dhs_pkg::TEMP_W-1:0]     out_current_temperature,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dhs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dhs_pkg::CFG_DATA_W-1:0] cfg_data
);

  dhs_pkg::cfg_t    cfg;
  dhs_pkg::item_t   in_item;
  dhs_pkg::item_t   s1_item_r;
  dhs_pkg::result_t step_res;
  dhs_pkg::result_t res_r;

  logic s1_vld_r, s1_vld_nxt;
  logic out_vld_r, out_vld_nxt;
  logic advance;
  logic in_take;

  assign cfg_ready = 1'b1;

  dhs_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  always_comb begin
    in_item.temperature       = in_temperature;
    in_item.temperature_valid = in_temperature_valid;
    in_item.run_request       = in_run_request;
    in_item.run_status_ok     = in_run_status_ok;
    in_item.fixed_power       = in_fixed_power;
    in_item.display_setup     = in_display_setup;
    in_item.tick_now          = in_tick_now;
  end

  assign advance  = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign s1_vld_nxt  = in_take || (s1_vld_r && !advance);
  assign out_vld_nxt = advance || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      res_r <= step_res;
    end
  end

  dhs_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .cfg    (cfg),
    .item   (s1_item_r),
    .result (step_res)
  );

  assign out_valid               = out_vld_r;
  assign out_heater_low_on       = res_r.heater_low_on;
  assign out_heater_high_on      = res_r.heater_high_on;
  assign out_converter_on        = res_r.converter_on;
  assign out_run_phase           = res_r.run_phase;
  assign out_heat_stage          = res_r.heat_stage;
  assign out_temperature_fault   = res_r.temperature_fault;
  assign out_current_temperature = res_r.current_temperature;

endmodule

// File: rtl/dhs_checker.sv
// ----------------------------------------------------------------------------
// Dryer heater sequencer port checker
// Watches the result channel of the core and flags illegal behaviour.
// ----------------------------------------------------------------------------
`include "dryer_heater_sequencer_core_macros.svh"

module dhs_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           out_heater_low_on,
  input logic                           out_heater_high_on,
  input logic                           out_converter_on,
  input logic [dhs_pkg::PHASE_W-1:0]    out_run_phase,
  input logic [dhs_pkg::STAGE_W-1:0]    out_heat_stage
);

  `DHS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `DHS_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_heat_stage) && $stable(out_run_phase) && $stable(out_heater_low_on) && $stable(out_heater_high_on))
  `DHS_ASSERT_IMP(a_stage_in_heat, out_valid && out_heat_stage != dhs_pkg::STG_START, out_run_phase == dhs_pkg::PH_HEAT && out_heat_stage <= dhs_pkg::STG_LAST)
  `DHS_ASSERT_IMP(a_conv_not_idle, out_valid && out_converter_on, out_run_phase != dhs_pkg::PH_IDLE)

endmodule

bind dryer_heater_sequencer_core dhs_checker u_dhs_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_heater_low_on  (out_heater_low_on),
  .out_heater_high_on (out_heater_high_on),
  .out_converter_on   (out_converter_on),
  .out_run_phase      (out_run_phase),
  .out_heat_stage     (out_heat_stage)
);

// File: sim/dryer_heater_sequencer_core_test.sv
// ----------------------------------------------------------------------------
// Dryer heater sequencer core testbench
// Drives control-period beats through the core with random gaps and random
// back-pressure. A shadow copy of the run phase machine, the heater stages
// and the sample fault counter predicts every result beat, and each beat is
// checked field by field. The run covers a directed opening, then sessions
// of idle, run and cool-down beats under several register settings,
// including the extremes.
// ----------------------------------------------------------------------------
import dhs_pkg::*;

class dryer_shadow;
  cfg_t               settings;
  logic [TEMP_W-1:0]  last_temp;
  logic [FAULT_W-1:0] fault_cnt;
  logic [PHASE_W-1:0] phase;
  logic [TICK_W-1:0]  phase_stamp;
  logic [COOL_W-1:0]  cool_cnt;
  logic [STAGE_W-1:0] stage;
  logic [TICK_W-1:0]  stage_stamp;
  logic [1:0]         drive;
  logic               conv;
  result_t            due_results[$];
  int unsigned        failures;

  function new();
    settings = '{RST_STABLE_TEMP, RST_SETTLE_TICKS, RST_REHEAT_TICKS, RST_FULL_TICKS,
                 RST_COOLDOWN_TICKS, RST_COOL_TEMP, RST_COOL_SAMPLES, RST_FAULT_SAMPLES};
    last_temp   = RST_LAST_TEMP;
    fault_cnt   = '0;
    phase       = PH_IDLE;
    phase_stamp = '0;
    cool_cnt    = '0;
    stage       = STG_START;
    stage_stamp = '0;
    drive       = DRV_OFF;
    conv        = 1'b0;
    failures    = 0;
  endfunction

  function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_STABLE_TEMP:    settings.stable_temperature     = val[TEMP_W-1:0];
      CFG_SETTLE_TICKS:   settings.settle_ticks           = val[DWELL_W-1:0];
      CFG_REHEAT_TICKS:   settings.reheat_delay_ticks     = val[DWELL_W-1:0];
      CFG_FULL_TICKS:     settings.full_dwell_ticks       = val[DWELL_W-1:0];
      CFG_COOLDOWN_TICKS: settings.cooldown_timeout_ticks = val[DWELL_W-1:0];
      CFG_COOL_TEMP:      settings.cool_temperature       = val[TEMP_W-1:0];
      CFG_COOL_SAMPLES:   settings.cool_samples           = val[COOL_W-1:0];
      CFG_FAULT_SAMPLES:  settings.fault_samples          = val[FAULT_W-1:0];
      default: ;
    endcase
  endfunction

  function bit dwell_done(logic [TICK_W-1:0] now, logic [TICK_W-1:0] stamp,
                          logic [DWELL_W-1:0] span);
    logic [TICK_W-1:0] gap;
    gap = now - stamp;
    return gap >= TICK_W'(span);
  endfunction

  function void step_heaters(logic [TICK_W-1:0] now);
    if (last_temp < settings.stable_temperature) begin
      case (stage)
        STG_START: stage = STG_BOTH;
        STG_HIGH, STG_HOLD, STG_LOW: begin
          stage_stamp = now;
          stage = STG_REHEAT;
        end
        STG_REHEAT: if (dwell_done(now, stage_stamp, settings.reheat_delay_ticks)) begin
          stage = STG_BOTH;
        end
        default: ;
      endcase
    end else begin
      case (stage)
        STG_START, STG_REHEAT, STG_BOTH: begin
          stage = STG_HOLD;
          stage_stamp = now;
        end
        STG_HOLD: if (dwell_done(now, stage_stamp, settings.reheat_delay_ticks)) begin
          stage_stamp = now;
          stage = STG_HIGH;
        end
        STG_HIGH: if (dwell_done(now, stage_stamp, settings.full_dwell_ticks)) begin
          stage = STG_LOW;
        end
        default: ;
      endcase
    end
    case (stage)
      STG_BOTH: drive = DRV_BOTH;
      STG_HIGH: drive = DRV_HIGH;
      STG_LOW:  drive = DRV_LOW;
      default: ;
    endcase
  endfunction

  function void advance(item_t it);
    result_t want;
    if (it.temperature_valid) begin
      last_temp = it.temperature;
      if (it.temperature == '0 || it.temperature >= TEMP_OOR_HIGH) begin
        if (fault_cnt != '1) fault_cnt++;
      end else begin
        fault_cnt = '0;
      end
    end
    if (it.run_status_ok) begin
      case (phase)
        PH_IDLE: if (it.run_request) begin
          phase = PH_SETTLE;
          phase_stamp = it.tick_now;
          conv = 1'b1;
        end
        PH_SETTLE: begin
          if (!it.run_request) begin
            phase = PH_IDLE;
            conv = 1'b0;
          end
          if (dwell_done(it.tick_now, phase_stamp, settings.settle_ticks)) phase = PH_HEAT;
        end
        PH_HEAT: if (!it.run_request) begin
          phase_stamp = it.tick_now;
          phase = PH_COOL;
          cool_cnt = '0;
        end
        default: begin
          if (last_temp < settings.cool_temperature) begin
            if (cool_cnt != '1) cool_cnt++;
          end else begin
            cool_cnt = '0;
          end
          if (cool_cnt >= settings.cool_samples ||
              dwell_done(it.tick_now, phase_stamp, settings.cooldown_timeout_ticks)) begin
            phase = PH_IDLE;
            conv = 1'b0;
          end
        end
      endcase
      if (phase == PH_HEAT) begin
        step_heaters(it.tick_now);
      end else begin
        stage = STG_START;
        drive = DRV_OFF;
      end
    end else begin
      stage = STG_START;
      drive = DRV_OFF;
      conv = 1'b0;
    end
    // The fixed power codes share their encoding with the heater drive.
    if (it.fixed_power != DRV_OFF && it.run_request && !it.display_setup) begin
      drive = it.fixed_power;
    end
    want.heater_low_on       = drive[0];
    want.heater_high_on      = drive[1];
    want.converter_on        = conv;
    want.run_phase           = phase;
    want.heat_stage          = stage;
    want.temperature_fault   = (fault_cnt >= settings.fault_samples);
    want.current_temperature = last_temp;
    due_results.push_back(want);
  endfunction

  function void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      failures++;
    end
  endfunction

  function void compare(result_t got);
    result_t want;
    if (due_results.size() == 0) begin
      $error("result beat arrived with nothing outstanding");
      failures++;
      return;
    end
    want = due_results.pop_front();
    check_field("heater_low_on", want.heater_low_on, got.heater_low_on);
    check_field("heater_high_on", want.heater_high_on, got.heater_high_on);
    check_field("converter_on", want.converter_on, got.converter_on);
    check_field("run_phase", want.run_phase, got.run_phase);
    check_field("heat_stage", want.heat_stage, got.heat_stage);
    check_field("temperature_fault", want.temperature_fault, got.temperature_fault);
    check_field("current_temperature", want.current_temperature, got.current_temperature);
  endfunction

  function int pending();
    return due_results.size();
  endfunction
endclass

module dryer_heater_sequencer_core_test;
  localparam int QUIET_LIMIT = 3000;

  typedef enum {SESSION_IDLE, SESSION_RUN, SESSION_COOL, SESSION_FAULT,
                SESSION_NOISE} beat_kind_e;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [TEMP_W-1:0]     in_temperature;
  logic                  in_temperature_valid;
  logic                  in_run_request;
  logic                  in_run_status_ok;
  logic [1:0]            in_fixed_power;
  logic                  in_display_setup;
  logic [TICK_W-1:0]     in_tick_now;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_heater_low_on;
  logic                  out_heater_high_on;
  logic                  out_converter_on;
  logic [PHASE_W-1:0]    out_run_phase;
  logic [STAGE_W-1:0]    out_heat_stage;
  logic                  out_temperature_fault;
  logic [TEMP_W-1:0]     out_current_temperature;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dryer_shadow       shadow = new();
  int unsigned       beats_sent = 0;
  int unsigned       step_max = 0;
  logic [TICK_W-1:0] tick_q = '0;
  bit                idle_on = 1'b1;
  bit                stall_on = 1'b1;
  bit                tail = 1'b0;
  int                quiet_cycles = 0;

  dryer_heater_sequencer_core uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch
    item_t   seen;
    result_t got;
    logic    busy;
    busy = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        shadow.write_register(cfg_index, cfg_data);
        busy = 1'b1;
      end
      if (in_valid && !in_stall) begin
        seen = {in_temperature, in_temperature_valid, in_run_request, in_run_status_ok,
                in_fixed_power, in_display_setup, in_tick_now};
        shadow.advance(seen);
        busy = 1'b1;
      end
      if (out_valid && !out_stall) begin
        got = {out_heater_low_on, out_heater_high_on, out_converter_on, out_run_phase,
               out_heat_stage, out_temperature_fault, out_current_temperature};
        shadow.compare(got);
        busy = 1'b1;
      end
    end
    quiet_cycles <= busy ? 0 : quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  function automatic item_t make_item(int temp, bit valid, bit run, bit ok,
                                      logic [1:0] fixed, bit setup,
                                      logic [TICK_W-1:0] tick);
    item_t it;
    it.temperature       = TEMP_W'(temp);
    it.temperature_valid = valid;
    it.run_request       = run;
    it.run_status_ok     = ok;
    it.fixed_power       = fixed;
    it.display_setup     = setup;
    it.tick_now          = tick;
    return it;
  endfunction

  function automatic item_t next_beat(beat_kind_e kind);
    item_t it;
    int    t;
    tick_q = tick_q + $urandom_range(0, step_max);
    it.tick_now          = tick_q;
    it.temperature_valid = ($urandom_range(0, 7) != 0);
    it.run_status_ok     = ($urandom_range(0, 24) != 0);
    it.fixed_power       = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : DRV_OFF;
    it.display_setup     = ($urandom_range(0, 7) == 0);
    it.run_request       = 1'b0;
    t = $urandom_range(1, 98);
    case (kind)
      SESSION_RUN: begin
        it.run_request = 1'b1;
        t = int'(shadow.settings.stable_temperature) + int'($urandom_range(0, 24)) - 12;
        if (t < 1) t = 1;
        if (t > 98) t = 98;
      end
      SESSION_COOL: begin
        if (shadow.settings.cool_temperature > 1 && $urandom_range(0, 3) != 0) begin
          t = $urandom_range(1, shadow.settings.cool_temperature - 1);
        end
      end
      SESSION_FAULT: begin
        it.run_request = 1'b1;
        it.temperature_valid = 1'b1;
        t = ($urandom_range(0, 1) != 0) ? int'(TEMP_OOR_HIGH) : 0;
      end
      SESSION_NOISE: begin
        it.run_request       = 1'($urandom_range(0, 1));
        it.run_status_ok     = 1'($urandom_range(0, 1));
        it.temperature_valid = 1'($urandom_range(0, 1));
        it.display_setup     = 1'($urandom_range(0, 1));
        it.fixed_power       = 2'($urandom_range(0, 3));
        it.tick_now          = $urandom;
        t = $urandom_range(0, 99);
      end
      default: ;
    endcase
    if ((kind == SESSION_RUN || kind == SESSION_IDLE) && $urandom_range(0, 39) == 0) begin
      t = ($urandom_range(0, 1) != 0) ? int'(TEMP_OOR_HIGH) : 0;
    end
    it.temperature = TEMP_W'(t);
    return it;
  endfunction

  task automatic send_beat(input item_t it);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    {in_temperature, in_temperature_valid, in_run_request, in_run_status_ok,
     in_fixed_power, in_display_setup, in_tick_now} = it;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (shadow.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic apply_settings(input cfg_t s);
    put_register(CFG_STABLE_TEMP, CFG_DATA_W'(s.stable_temperature));
    put_register(CFG_SETTLE_TICKS, CFG_DATA_W'(s.settle_ticks));
    put_register(CFG_REHEAT_TICKS, CFG_DATA_W'(s.reheat_delay_ticks));
    put_register(CFG_FULL_TICKS, CFG_DATA_W'(s.full_dwell_ticks));
    put_register(CFG_COOLDOWN_TICKS, CFG_DATA_W'(s.cooldown_timeout_ticks));
    put_register(CFG_COOL_TEMP, CFG_DATA_W'(s.cool_temperature));
    put_register(CFG_COOL_SAMPLES, CFG_DATA_W'(s.cool_samples));
    put_register(CFG_FAULT_SAMPLES, CFG_DATA_W'(s.fault_samples));
    cfg_valid = 1'b0;
  endtask

  task automatic send_session();
    int unsigned n;
    if (!tail) begin
      idle_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
    end
    repeat ($urandom_range(1, 3)) send_beat(next_beat(SESSION_IDLE));
    n = $urandom_range(10, 60);
    repeat (n) begin
      if ($urandom_range(0, 149) == 0) begin
        repeat ($urandom_range(shadow.settings.fault_samples,
                               shadow.settings.fault_samples + 8)) begin
          send_beat(next_beat(SESSION_FAULT));
        end
      end
      send_beat(next_beat(SESSION_RUN));
    end
    repeat ($urandom_range(5, 30)) send_beat(next_beat(SESSION_COOL));
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 5)) send_beat(next_beat(SESSION_NOISE));
    end
    if ($urandom_range(0, 9) == 0) wait_drained();
  endtask

  task automatic play_settings(input cfg_t s, input int unsigned step,
                               input int unsigned count);
    int unsigned target;
    wait_drained();
    apply_settings(s);
    step_max = step;
    tick_q = 32'hFFFF_FFFF - $urandom_range(0, step * 30);
    target = beats_sent + count;
    while (beats_sent < target) send_session();
  endtask

  initial begin
    logic [TICK_W-1:0] t0;
    cfg_t              s;
    rst_n                = 1'b0;
    in_valid             = 1'b0;
    in_temperature       = '0;
    in_temperature_valid = 1'b0;
    in_run_request       = 1'b0;
    in_run_status_ok     = 1'b0;
    in_fixed_power       = DRV_OFF;
    in_display_setup     = 1'b0;
    in_tick_now          = '0;
    cfg_valid            = 1'b0;
    cfg_index            = CFG_STABLE_TEMP;
    cfg_data             = '0;
    t0 = 32'hFFFF_FE00;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    send_beat(make_item(0, 1, 0, 1, DRV_OFF, 0, t0));
    send_beat(make_item(99, 1, 1, 0, DRV_BOTH, 0, t0));
    send_beat(make_item(50, 1, 1, 1, DRV_OFF, 1, t0 + 10));
    send_beat(make_item(50, 1, 0, 1, DRV_OFF, 0, t0 + 20));
    send_beat(make_item(50, 1, 1, 1, DRV_HIGH, 1, t0 + 30));
    send_beat(make_item(80, 0, 1, 1, DRV_LOW, 0, t0 + 1030));
    send_beat(make_item(70, 1, 1, 1, DRV_OFF, 0, t0 + 1040));
    send_beat(make_item(70, 1, 1, 1, DRV_OFF, 0, t0 + 3040));
    send_beat(make_item(70, 1, 1, 1, DRV_OFF, 0, t0 + 8040));
    send_beat(make_item(40, 1, 1, 1, DRV_OFF, 0, t0 + 8050));
    send_beat(make_item(40, 1, 1, 1, DRV_OFF, 0, t0 + 10050));
    send_beat(make_item(40, 1, 1, 0, DRV_OFF, 0, t0 + 10060));
    send_beat(make_item(40, 1, 1, 1, DRV_OFF, 0, t0 + 10070));
    send_beat(make_item(40, 1, 0, 1, DRV_OFF, 0, t0 + 10080));
    send_beat(make_item(20, 1, 0, 1, DRV_OFF, 0, t0 + 10090));
    send_beat(make_item(20, 1, 0, 1, DRV_OFF, 0, t0 + 40090));
    send_beat(make_item(0, 1, 1, 1, DRV_OFF, 0, t0 + 40100));
    send_beat(make_item(99, 1, 1, 1, DRV_BOTH, 0, t0 + 40110));
    send_beat(make_item(98, 1, 1, 1, DRV_OFF, 0, 32'hFFFF_FFFF));
    send_beat(make_item(1, 1, 0, 1, DRV_OFF, 0, 32'h0000_0000));
    send_beat(make_item(10, 0, 1, 0, DRV_LOW, 1, 32'h0000_0010));

    s = '{RST_STABLE_TEMP, RST_SETTLE_TICKS, RST_REHEAT_TICKS, RST_FULL_TICKS,
          RST_COOLDOWN_TICKS, RST_COOL_TEMP, RST_COOL_SAMPLES, RST_FAULT_SAMPLES};
    play_settings(s, 800, 160);

    s = '{7'd55, 16'd20, 16'd15, 16'd30, 16'd120, 7'd40, 8'd3, 6'd4};
    play_settings(s, 10, 160);

    s = '0;
    play_settings(s, 3, 70);

    s = '{7'd99, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd99, 8'd255, 6'd63};
    play_settings(s, 20000, 110);

    s.stable_temperature     = TEMP_W'($urandom_range(20, 80));
    s.settle_ticks           = DWELL_W'($urandom_range(0, 300));
    s.reheat_delay_ticks     = DWELL_W'($urandom_range(0, 300));
    s.full_dwell_ticks       = DWELL_W'($urandom_range(0, 600));
    s.cooldown_timeout_ticks = DWELL_W'($urandom_range(50, 2000));
    s.cool_temperature       = TEMP_W'($urandom_range(10, 60));
    s.cool_samples           = COOL_W'($urandom_range(1, 8));
    s.fault_samples          = FAULT_W'($urandom_range(1, 10));
    tail     = 1'b1;
    idle_on  = 1'b0;
    stall_on = 1'b0;
    play_settings(s, 60, 140);

    wait_drained();
    repeat (6) @(negedge clk);
    if (shadow.failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
